/* rtl/xtea_pkg.sv */
package xtea_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned KEY_COUNT = 4;
    localparam int unsigned KEY_IDX_W = $clog2(KEY_COUNT);
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CYCLE_COUNT_DEFAULT = 32;
    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = CFG_IDX_W'(3);

    // opcode values carried in tuser
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // feistel mixing term: ((v << 4) ^ (v >> 5)) + v
    function automatic word_t mix(input word_t v);
        word_t sh;
        sh = (v << 4) ^ (v >> 5);
        return sh + v;
    endfunction

    // round sum seen by half-round stage j (elaboration-time constant)
    function automatic word_t stage_sum(input int unsigned j, input logic dec,
                                        input int unsigned cycles);
        int unsigned c;
        int unsigned mult;
        logic [63:0] prod;
        c = j / 2;
        if (dec == OP_ENCRYPT) begin
            mult = ((j % 2) == 0) ? c : c + 1;
        end else begin
            mult = ((j % 2) == 0) ? cycles - c : cycles - c - 1;
        end
        prod = 64'(XTEA_DELTA) * 64'(mult);
        return prod[WORD_W-1:0];
    endfunction

    // key index for stage j: sum[1:0] when word a is updated, sum[12:11] for word b
    function automatic logic [KEY_IDX_W-1:0] stage_key_idx(input int unsigned j,
                                                          input logic dec,
                                                          input int unsigned cycles);
        word_t s;
        logic upd_a;
        s = stage_sum(j, dec, cycles);
        upd_a = ((j % 2) == 0) ? (dec == OP_ENCRYPT) : (dec == OP_DECRYPT);
        return upd_a ? s[KEY_IDX_W-1:0] : s[11 +: KEY_IDX_W];
    endfunction

endpackage

/* rtl/xtea_block_cipher_core.sv */
// XTEA block cipher, ECB mode, 64-bit block, 128-bit key from four config words.
// Each item is one block (first word in s_tdata[31:0], second in s_tdata[63:32]),
// encrypted when s_tuser is 0 and decrypted when it is 1; tlast passes through.
// Every half-round of the cipher is one register stage, so the pipeline is
// 2*CYCLE_COUNT stages deep, the result channel comes straight from the last stage,
// and one block can be taken every clock unless the output is stalled. The whole pipeline
// advances together and holds when the output register is full and m_tready is low.
// Key words are written through the cfg port (index 0..3, others ignored) and
// must only change while no block is in flight. Both ready outputs are low in reset.
module xtea_block_cipher_core #(
    parameter int unsigned CYCLE_COUNT = xtea_pkg::CYCLE_COUNT_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]    cfg_data,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [2*xtea_pkg::WORD_W-1:0]  s_tdata,   // first_word, second_word
    input  logic                           s_tuser,   // opcode
    input  logic                           s_tlast,   // last_block
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*xtea_pkg::WORD_W-1:0]  m_tdata,   // out_first_word, out_second_word
    output logic                           m_tlast    // out_last_block
);
    import xtea_pkg::*;

    localparam int unsigned STAGES = 2 * CYCLE_COUNT;

    word_t key_reg [KEY_COUNT];

    word_t a_reg    [STAGES];
    word_t b_reg    [STAGES];
    logic  op_reg   [STAGES];
    logic  last_reg [STAGES];
    logic  valid_reg[STAGES];

    word_t a_next   [STAGES];
    word_t b_next   [STAGES];

    logic  adv;

    // key registers
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                key_reg[k] <= '0;
            end
        end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(KEY_COUNT))) begin
            key_reg[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
        end
    end

    // whole pipeline moves unless the output register is stuck
    assign adv      = !valid_reg[STAGES-1] || m_tready;
    assign s_tready = adv && aresetn;

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        localparam word_t SUM_ENC = stage_sum(j, OP_ENCRYPT, CYCLE_COUNT);
        localparam word_t SUM_DEC = stage_sum(j, OP_DECRYPT, CYCLE_COUNT);
        localparam logic [KEY_IDX_W-1:0] KI_ENC = stage_key_idx(j, OP_ENCRYPT, CYCLE_COUNT);
        localparam logic [KEY_IDX_W-1:0] KI_DEC = stage_key_idx(j, OP_DECRYPT, CYCLE_COUNT);
        localparam bit EVEN = ((j % 2) == 0);

        word_t a_in, b_in, src, dst, sk, f, res;
        logic  op_in, last_in, valid_in, dec, upd_a;

        // stage inputs: ports for the first stage, previous stage otherwise
        if (j == 0) begin : g_first
            assign a_in     = s_tdata[WORD_W-1:0];
            assign b_in     = s_tdata[2*WORD_W-1:WORD_W];
            assign op_in    = s_tuser;
            assign last_in  = s_tlast;
            assign valid_in = s_tvalid;
        end else begin : g_mid
            assign a_in     = a_reg[j-1];
            assign b_in     = b_reg[j-1];
            assign op_in    = op_reg[j-1];
            assign last_in  = last_reg[j-1];
            assign valid_in = valid_reg[j-1];
        end

        // one half-round: dst +/-= mix(src) ^ (sum + key)
        always_comb begin
            dec   = (op_in == OP_DECRYPT);
            upd_a = EVEN ? !dec : dec;
            src   = upd_a ? b_in : a_in;
            dst   = upd_a ? a_in : b_in;
            sk    = dec ? (SUM_DEC + key_reg[KI_DEC]) : (SUM_ENC + key_reg[KI_ENC]);
            f     = mix(src) ^ sk;
            res   = dec ? (dst - f) : (dst + f);
            a_next[j] = upd_a ? res : a_in;
            b_next[j] = upd_a ? b_in : res;
        end

        // stage valid
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (adv) begin
                valid_reg[j] <= valid_in;
            end
        end

        // stage payload
        always_ff @(posedge aclk) begin
            if (adv) begin
                a_reg[j]    <= a_next[j];
                b_reg[j]    <= b_next[j];
                op_reg[j]   <= op_in;
                last_reg[j] <= last_in;
            end
        end
    end

    // result channel straight from the last stage
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {b_reg[STAGES-1], a_reg[STAGES-1]};
    assign m_tlast  = last_reg[STAGES-1];

    // no item enters while a result is stuck at the output
    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    // valid bits move one stage on each advance
    a_valid_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(adv) |-> (m_tvalid == $past(valid_reg[STAGES-2])))
        else $error("valid bit lost or invented in pipeline");

    // a held result keeps its data
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(m_tvalid && !m_tready) |-> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // pipeline empty right after reset
    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule
